// File: design/mdh_fk_pkg.sv
package mdh_fk_pkg;

    localparam int ANG_W  = 16;
    localparam int POS_W  = 20;
    localparam int QUAT_W = 16;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;
    localparam int NUM_REGS = 6;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
    localparam int CORDIC_STEPS = 16;

    typedef struct packed {
        logic signed [ANG_W-1:0] joint1_angle;
        logic signed [ANG_W-1:0] joint2_angle;
        logic signed [ANG_W-1:0] joint3_angle;
        logic signed [ANG_W-1:0] joint4_angle;
        logic signed [ANG_W-1:0] joint5_angle;
        logic signed [ANG_W-1:0] joint6_angle;
    } t_fk_in;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic                     degenerate;
    } t_fk_out;

    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_trig_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_trig_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG_T,
        ST_WAIT_T,
        ST_TRIG_A,
        ST_WAIT_A,
        ST_LINK,
        ST_MAC,
        ST_NEXT,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic [31:0] atan_entry(input logic [3:0] i);
        logic [31:0] v;
        begin
            case (i)
                4'd0:  v = 32'h20000000;
                4'd1:  v = 32'h12E4051D;
                4'd2:  v = 32'h09FB385B;
                4'd3:  v = 32'h051111D4;
                4'd4:  v = 32'h028B0D43;
                4'd5:  v = 32'h0145D7E1;
                4'd6:  v = 32'h00A2F61E;
                4'd7:  v = 32'h00517C55;
                4'd8:  v = 32'h0028BE53;
                4'd9:  v = 32'h00145F2E;
                4'd10: v = 32'h000A2F98;
                4'd11: v = 32'h000517CC;
                4'd12: v = 32'h00028BE6;
                4'd13: v = 32'h000145F3;
                4'd14: v = 32'h0000A2F9;
                default: v = 32'h0000517C;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [47:0] v);
        logic signed [31:0] r;
        begin
            if (v > 48'sd1073741824) r = ONE_Q30;
            else if (v < -48'sd1073741824) r = -ONE_Q30;
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage

// File: design/mdh_fk_cordic.sv
module mdh_fk_cordic
    import mdh_fk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_trig_req i_req,
    output t_trig_rsp o_rsp
);

    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] n_x, n_y, n_z;
    logic [3:0]  r_i;
    logic [1:0]  r_quad;
    logic        r_run;
    logic        r_done;
    logic signed [33:0] dx, dy, at;
    logic signed [31:0] cx, cy;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = 34'(atan_entry(r_i));

    always_comb begin
        if (r_z >= 0) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_i    <= '0;
                r_quad <= i_req.angle[15:14];
                r_x    <= 34'(CORDIC_K);
                r_y    <= '0;
                r_z    <= {4'd0, i_req.angle[13:0], 16'd0};
            end else if (r_run) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign cx = clamp_q30(48'(r_x));
    assign cy = clamp_q30(48'(r_y));

    always_comb begin
        o_rsp.done = r_done;
        case (r_quad)
            2'd0: begin o_rsp.cos_v = cx;  o_rsp.sin_v = cy;  end
            2'd1: begin o_rsp.cos_v = -cy; o_rsp.sin_v = cx;  end
            2'd2: begin o_rsp.cos_v = -cx; o_rsp.sin_v = -cy; end
            default: begin o_rsp.cos_v = cy; o_rsp.sin_v = -cx; end
        endcase
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("cordic done held");
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run) else $error("cordic done while running");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (cx <= ONE_Q30 && cx >= -ONE_Q30)) else $error("cordic range");
`endif

endmodule

// File: design/mdh_forward_kinematics_6dof_top.sv
// Forward kinematics of a serial arm with modified DH links. Pulse start
// while busy is low; busy then stays high while the pose is computed. Each
// joint takes two 16-step CORDIC runs, a state to build the link, the
// multiply-accumulate through one shared 32x32 multiplier (three rotation
// columns and the position, three products and a writeback per row), and a
// state to advance. After the joints come a square root, three restoring
// divides and an output state. A degenerate orientation skips the root and
// the divides. o_done is high for one cycle with the result on o_result, in
// the first cycle that busy is low; the receiver cannot stall, so it must
// take the transfer in that cycle. Link registers are written through
// i_cfg_we; the user must write them only while the block is idle, as
// the block itself does not enforce it.
module mdh_forward_kinematics_6dof_top
    import mdh_fk_pkg::*;
#(
    parameter int NUM_JOINTS = 6
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_fk_in             i_data,
    output logic               o_done,
    output t_fk_out            o_result,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [CFG_W-1:0] r_link [NUM_REGS];
    logic [ANG_W-1:0] r_ang [NUM_REGS];
    t_state r_state, n_state;
    logic [2:0] r_j;
    logic [4:0] r_k;
    logic [5:0] r_cnt;

    logic signed [31:0] r_ct, r_st, r_ca, r_sa;
    logic signed [31:0] r_r [9];
    logic signed [31:0] r_nr [9];
    logic signed [31:0] r_li [9];
    logic signed [47:0] r_p [3];
    logic signed [47:0] r_lp [3];
    logic signed [79:0] r_acc;

    t_trig_req trig_req;
    t_trig_rsp trig_rsp;

    logic [63:0] cur;
    logic [15:0] theta;

    assign cur   = r_link[r_j];
    assign theta = r_ang[r_j] + cur[63:48];

    mdh_fk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trig_req),
        .o_rsp   (trig_rsp)
    );

    always_comb begin
        trig_req.start = (r_state == ST_TRIG_T) || (r_state == ST_TRIG_A);
        trig_req.angle = (r_state == ST_TRIG_T) ? theta : cur[15:0];
    end

    // shared multiply: one 32x32 product per cycle
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic [1:0] row, col, tt;
    assign row = 2'(r_k / 4);
    assign tt  = r_k[1:0];
    assign col = 2'(r_cnt);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MAC) begin
            if (tt == 2'd3) begin
                mul_a = '0;
                mul_b = '0;
            end else begin
                mul_a = r_r[row*3 + tt];
                if (col == 2'd3) mul_b = r_lp[tt][31:0];
                else mul_b = r_li[tt*3 + col];
            end
        end
    end
    assign prod = mul_a * mul_b;

    // square root and divide state
    logic [63:0] r_sq_n, r_sq_res, r_sq_bit;
    logic [31:0] r_v;
    logic [1:0]  r_qi;
    logic [47:0] r_rem, r_den, r_quo, r_num;
    logic        r_neg, r_deg;
    logic signed [33:0] s_val;
    assign s_val = 34'(ONE_Q30) + 34'(r_r[0]) + 34'(r_r[4]) + 34'(r_r[8]);

    logic signed [32:0] qnum;
    always_comb begin
        case (r_qi)
            2'd0: qnum = 33'(r_r[5]) - 33'(r_r[7]);
            2'd1: qnum = 33'(r_r[6]) - 33'(r_r[2]);
            default: qnum = 33'(r_r[1]) - 33'(r_r[3]);
        endcase
    end

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        begin
            if (v > 48'sd32767) r = 16'sh7FFF;
            else if (v < -48'sd32768) r = 16'sh8000;
            else r = v[15:0];
            return r;
        end
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
        logic signed [47:0] t;
        logic signed [19:0] r;
        begin
            t = (v + 48'sd128) >>> 8;
            if (t > 48'sd524287) r = 20'sh7FFFF;
            else if (t < -48'sd524288) r = 20'sh80000;
            else r = t[19:0];
            return r;
        end
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_TRIG_T;
            ST_TRIG_T: n_state = ST_WAIT_T;
            ST_WAIT_T: if (trig_rsp.done) n_state = ST_TRIG_A;
            ST_TRIG_A: n_state = ST_WAIT_A;
            ST_WAIT_A: if (trig_rsp.done) n_state = ST_LINK;
            ST_LINK:   n_state = ST_MAC;
            ST_MAC:    if (r_cnt == 6'd3 && r_k == 5'd11) n_state = ST_NEXT;
            ST_NEXT:   if (r_j == 3'(NUM_JOINTS - 1)) n_state = ST_SQRT;
                       else n_state = ST_TRIG_T;
            ST_SQRT:   if (s_val <= 0) n_state = ST_DONE;
                       else if (r_sq_bit == 64'd0 && r_cnt != 6'd0) n_state = ST_DIV;
            ST_DIV:    if (r_qi == 2'd2 && r_cnt == 6'd49) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) r_link[i] <= '0;
        end else begin
            r_state <= n_state;
            o_done  <= (r_state == ST_DONE);
            if (i_cfg_we && i_cfg_idx < 3'(NUM_REGS)) r_link[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_j <= '0;
                r_ang[0] <= i_data.joint1_angle;
                r_ang[1] <= i_data.joint2_angle;
                r_ang[2] <= i_data.joint3_angle;
                r_ang[3] <= i_data.joint4_angle;
                r_ang[4] <= i_data.joint5_angle;
                r_ang[5] <= i_data.joint6_angle;
                for (int i = 0; i < 9; i++)
                    r_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q30 : 32'sd0;
                for (int i = 0; i < 3; i++) r_p[i] <= '0;
            end
            ST_WAIT_T: if (trig_rsp.done) begin
                r_ct <= trig_rsp.cos_v;
                r_st <= trig_rsp.sin_v;
            end
            ST_WAIT_A: if (trig_rsp.done) begin
                r_ca <= trig_rsp.cos_v;
                r_sa <= trig_rsp.sin_v;
                r_cnt <= '0;
            end
            ST_LINK: begin
                // link rotation built with the shared clamp; four small products
                r_li[0] <= r_ct;
                r_li[1] <= -r_st;
                r_li[2] <= '0;
                r_li[3] <= clamp_q30(48'((64'(r_st) * 64'(r_ca) + 64'sd536870912) >>> 30));
                r_li[4] <= clamp_q30(48'((64'(r_ct) * 64'(r_ca) + 64'sd536870912) >>> 30));
                r_li[5] <= -r_sa;
                r_li[6] <= clamp_q30(48'((64'(r_st) * 64'(r_sa) + 64'sd536870912) >>> 30));
                r_li[7] <= clamp_q30(48'((64'(r_ct) * 64'(r_sa) + 64'sd536870912) >>> 30));
                r_li[8] <= r_ca;
                r_lp[0] <= 48'(signed'(cur[31:16])) <<< 8;
                r_lp[1] <= 48'((-(64'(signed'(cur[47:32])) * 64'(r_sa)) + 64'sd2097152) >>> 22);
                r_lp[2] <= 48'(((64'(signed'(cur[47:32])) * 64'(r_ca)) + 64'sd2097152) >>> 22);
                r_k <= '0;
                r_cnt <= '0;
                r_acc <= '0;
            end
            ST_MAC: begin
                // r_cnt: column 0..2 rotation, 3 position; r_k: row*4 + term
                if (tt == 2'd3) begin
                    if (col == 2'd3)
                        r_p[row] <= r_p[row] + 48'((r_acc + 80'sd536870912) >>> 30);
                    else
                        r_nr[row*3 + col] <= clamp_q30(48'((r_acc + 80'sd536870912) >>> 30));
                    r_acc <= '0;
                    if (r_k == 5'd11) begin
                        r_k <= '0;
                        r_cnt <= r_cnt + 6'd1;
                    end else r_k <= r_k + 5'd1;
                end else begin
                    r_acc <= r_acc + 80'(prod);
                    r_k <= r_k + 5'd1;
                end
            end
            ST_NEXT: begin
                for (int i = 0; i < 9; i++) r_r[i] <= r_nr[i];
                r_j <= r_j + 3'd1;
                r_cnt <= '0;
            end
            ST_SQRT: begin
                r_deg <= (s_val <= 0);
                if (r_cnt == 6'd0) begin
                    r_sq_n <= 64'(s_val) << 30;
                    r_sq_res <= '0;
                    r_sq_bit <= 64'd1 << 62;
                    r_cnt <= 6'd1;
                end else if (r_sq_bit != 64'd0) begin
                    if (r_sq_n >= r_sq_res + r_sq_bit) begin
                        r_sq_n <= r_sq_n - (r_sq_res + r_sq_bit);
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else r_sq_res <= r_sq_res >> 1;
                    r_sq_bit <= r_sq_bit >> 2;
                end else begin
                    r_v <= r_sq_res[31:0];
                    r_qi <= '0;
                    r_cnt <= '0;
                end
            end
            ST_DIV: begin
                // restoring divide: (2*|num|*2^14 + 2v) / 4v
                if (r_cnt == 6'd0) begin
                    r_neg <= qnum[32];
                    r_num <= ((48'(qnum[32] ? -qnum : qnum) << 15) + (48'(r_v) << 1));
                    r_den <= 48'(r_v) << 2;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 6'd1;
                end else if (r_cnt <= 6'd48) begin
                    if ({r_rem[46:0], r_num[47]} >= r_den) begin
                        r_rem <= {r_rem[46:0], r_num[47]} - r_den;
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[46:0], r_num[47]};
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 6'd1;
                end else begin
                    case (r_qi)
                        2'd0: o_result.quat_x <= sat16(r_neg ? -r_quo : r_quo);
                        2'd1: o_result.quat_y <= sat16(r_neg ? -r_quo : r_quo);
                        default: o_result.quat_z <= sat16(r_neg ? -r_quo : r_quo);
                    endcase
                    r_qi <= r_qi + 2'd1;
                    r_cnt <= '0;
                end
            end
            ST_DONE: begin
                o_result.pos_x <= sat20(r_p[0]);
                o_result.pos_y <= sat20(r_p[1]);
                o_result.pos_z <= sat20(r_p[2]);
                o_result.degenerate <= r_deg;
                if (r_deg) begin
                    o_result.quat_w <= '0;
                    o_result.quat_x <= '0;
                    o_result.quat_y <= '0;
                    o_result.quat_z <= '0;
                end else
                    o_result.quat_w <= sat16(48'((64'(r_v) + 64'd65536) >> 17));
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start ignored");
`endif

endmodule

// File: test/mdh_forward_kinematics_6dof_top_tb.sv
module mdh_forward_kinematics_6dof_top_tb
    import mdh_fk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_JOINTS   = 6;
    localparam int N_RAND     = 1170;
    localparam int N_PHASES   = 8;
    localparam int DRAIN_CYC  = 600;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint GAIN_X0 = 64'sd652032874;
    localparam longint ATAN_LUT [16] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    // joint angles j1..j6, j1 in the top bits
    localparam logic [95:0] JOINT_TAB [12] = '{
        96'h0000_0000_0000_0000_0000_0000,
        96'h7FFF_7FFF_7FFF_7FFF_7FFF_7FFF,
        96'h8000_8000_8000_8000_8000_8000,
        96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF,
        96'h4000_4000_4000_4000_4000_4000,
        96'hC000_C000_C000_C000_C000_C000,
        96'h8000_0000_0000_0000_0000_0000,
        96'h8000_8000_0000_0000_0000_0000,
        96'h0000_0000_0000_0000_0000_8000,
        96'h5555_AAAA_5555_AAAA_5555_AAAA,
        96'hAAAA_5555_AAAA_5555_AAAA_5555,
        96'h0001_FFFE_2000_E000_7FFE_8001
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_fk_in           i_data;
    logic             o_done;
    t_fk_out          o_result;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    logic [CFG_W-1:0] link_regs [N_JOINTS];
    t_fk_out          pose_q [$];
    int               err_cnt;
    int               idle_pct;

    mdh_forward_kinematics_6dof_top #(.NUM_JOINTS(N_JOINTS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_data     (i_data),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_sh(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        begin
            x = GAIN_X0;
            y = 0;
            z = longint'(ang[13:0]) <<< 16;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_LUT[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_LUT[i];
                end
            end
            x = clip(x, -Q30_ONE, Q30_ONE);
            y = clip(y, -Q30_ONE, Q30_ONE);
            case (ang[15:14])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        end
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        begin
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic [15:0] quat_vec(input longint num, input longint v);
        longint den, mag, q;
        begin
            den = 2 * v;
            mag = ((num < 0) ? -num : num) * 16384;
            q = (2 * mag + den) / (2 * den);
            if (num < 0) q = -q;
            return 16'(clip(q, -32768, 32767));
        end
    endfunction

    function automatic t_fk_out end_pose(input t_fk_in ang);
        longint rot [3][3], nrot [3][3], lrot [3][3];
        longint pos [3], lpos [3];
        longint ct, st, ca, sa, len, offs, acc, s, v;
        logic [15:0] jang [6];
        logic [15:0] theta;
        logic [63:0] reg_v;
        t_fk_out o;
        begin
            jang = '{ang.joint1_angle, ang.joint2_angle, ang.joint3_angle,
                     ang.joint4_angle, ang.joint5_angle, ang.joint6_angle};
            for (int i = 0; i < 3; i++) begin
                pos[i] = 0;
                for (int k = 0; k < 3; k++) rot[i][k] = (i == k) ? Q30_ONE : 0;
            end
            for (int j = 0; j < N_JOINTS; j++) begin
                reg_v = link_regs[j];
                len   = longint'($signed(reg_v[31:16]));
                offs  = longint'($signed(reg_v[47:32]));
                theta = jang[j] + reg_v[63:48];
                sin_cos(theta, ct, st);
                sin_cos(reg_v[15:0], ca, sa);
                lrot[0][0] = ct;
                lrot[0][1] = -st;
                lrot[0][2] = 0;
                lrot[1][0] = clip(round_sh(st * ca, 30), -Q30_ONE, Q30_ONE);
                lrot[1][1] = clip(round_sh(ct * ca, 30), -Q30_ONE, Q30_ONE);
                lrot[1][2] = -sa;
                lrot[2][0] = clip(round_sh(st * sa, 30), -Q30_ONE, Q30_ONE);
                lrot[2][1] = clip(round_sh(ct * sa, 30), -Q30_ONE, Q30_ONE);
                lrot[2][2] = ca;
                lpos[0] = len * 256;
                lpos[1] = round_sh(-offs * sa, 22);
                lpos[2] = round_sh(offs * ca, 22);
                for (int i = 0; i < 3; i++) begin
                    acc = rot[i][0] * lpos[0] + rot[i][1] * lpos[1] + rot[i][2] * lpos[2];
                    pos[i] = pos[i] + round_sh(acc, 30);
                end
                for (int i = 0; i < 3; i++)
                    for (int k = 0; k < 3; k++) begin
                        acc = rot[i][0] * lrot[0][k] + rot[i][1] * lrot[1][k]
                            + rot[i][2] * lrot[2][k];
                        nrot[i][k] = clip(round_sh(acc, 30), -Q30_ONE, Q30_ONE);
                    end
                rot = nrot;
            end
            o.pos_x = 20'(clip(round_sh(pos[0], 8), -524288, 524287));
            o.pos_y = 20'(clip(round_sh(pos[1], 8), -524288, 524287));
            o.pos_z = 20'(clip(round_sh(pos[2], 8), -524288, 524287));
            s = Q30_ONE + rot[0][0] + rot[1][1] + rot[2][2];
            if (s <= 0) begin
                o.quat_w = '0; o.quat_x = '0; o.quat_y = '0; o.quat_z = '0;
                o.degenerate = 1'b1;
            end else begin
                v = longint'(int_sqrt(64'(s) << 30));
                o.quat_w = 16'(clip(round_sh(v, 17), -32768, 32767));
                o.quat_x = quat_vec(rot[1][2] - rot[2][1], v);
                o.quat_y = quat_vec(rot[2][0] - rot[0][2], v);
                o.quat_z = quat_vec(rot[0][1] - rot[1][0], v);
                o.degenerate = 1'b0;
            end
            return o;
        end
    endfunction

    task automatic write_link(input int idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= val;
        if (idx < N_JOINTS) link_regs[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pose_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic send_pose(input t_fk_in ang);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_data <= ang;
        do @(posedge i_clk); while (busy);
        pose_q.push_back(end_pose(ang));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic logic [63:0] rand_link();
        logic [63:0] v;
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(3))
                0: v[15:0] = 16'(($urandom_range(3)) << 14);
                1: v[47:16] = {$urandom_range(1) ? 16'h8000 : 16'h7FFF, v[31:16]};
                default: ;
            endcase
            return v;
        end
    endfunction

    function automatic t_fk_in rand_angles();
        t_fk_in a;
        begin
            a = {$urandom, $urandom, $urandom};
            if ($urandom_range(7) == 0) begin
                a.joint1_angle = 16'h8000;
                a.joint2_angle = $urandom_range(1) ? 16'h0000 : 16'h8000;
            end
            return a;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fk_out exp_v;
        if (i_rst_n && o_done) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose transfer %h", $time, o_result);
                err_cnt++;
            end else begin
                exp_v = pose_q.pop_front();
                if (o_result !== exp_v) begin
                    $display("%0t: pose mismatch exp x=%0d y=%0d z=%0d w=%0d qx=%0d qy=%0d qz=%0d dg=%0b",
                             $time, exp_v.pos_x, exp_v.pos_y, exp_v.pos_z, exp_v.quat_w,
                             exp_v.quat_x, exp_v.quat_y, exp_v.quat_z, exp_v.degenerate);
                    $display("%0t: pose mismatch act x=%0d y=%0d z=%0d w=%0d qx=%0d qy=%0d qz=%0d dg=%0b",
                             $time, o_result.pos_x, o_result.pos_y, o_result.pos_z,
                             o_result.quat_w, o_result.quat_x, o_result.quat_y,
                             o_result.quat_z, o_result.degenerate);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int sent;
        int per_phase;
        sent       = 0;
        err_cnt    = 0;
        idle_pct   = 28;
        per_phase  = N_RAND / N_PHASES;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        for (int j = 0; j < N_JOINTS; j++) link_regs[j] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // link setup between phases, block idle
            if (ph > 0) begin
                wait_drained();
                @(negedge i_clk);
                start <= 1'b0;
                for (int j = 0; j < NUM_REGS; j++) begin
                    case (ph)
                        1: write_link(j, 64'hFFFF_FFFF_FFFF_FFFF);
                        2: write_link(j, 64'h8000_8000_8000_8000);
                        3: write_link(j, 64'h7FFF_7FFF_7FFF_7FFF);
                        default: write_link(j, rand_link());
                    endcase
                end
                write_link(6, {$urandom, $urandom});
                write_link(7, {$urandom, $urandom});
            end
            if (ph < 2)
                foreach (JOINT_TAB[r]) send_pose(t_fk_in'(JOINT_TAB[r]));
            for (int n = 0; n < per_phase + ((ph == N_PHASES - 1) ? N_RAND % N_PHASES : 0); n++) begin
                idle_pct = (sent < N_RAND / 3) ? 28 : ((sent < 2 * N_RAND / 3) ? 85 : 0);
                send_pose(rand_angles());
                sent++;
            end
        end
        @(negedge i_clk);
        start <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0 && pose_q.size() == 0) begin
            $display("[mdh_forward_kinematics_6dof_top] OK");
        end else begin
            $display("[mdh_forward_kinematics_6dof_top] ERROR");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("[mdh_forward_kinematics_6dof_top] ERROR");
        $finish;
    end

endmodule
